// File: design/frt_pkg.sv
package frt_pkg;

    localparam int FID_W = 32;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int TS_W  = 48;
    localparam int STS_W = 2;

    localparam int FRAME_SLOTS_DEF = 256;
    localparam int MAX_PKTS_DEF    = 64;
    localparam int TIME_BITS_DEF   = 48;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    // Register index, taken from the address bits above the 8-byte word offset.
    localparam logic REG_DEADLINE = 1'b0;

    localparam logic [STS_W-1:0] ST_IGNORED = 2'd0;
    localparam logic [STS_W-1:0] ST_PARTIAL = 2'd1;
    localparam logic [STS_W-1:0] ST_DONE    = 2'd2;

    typedef struct packed {
        logic [FID_W-1:0] frame_id;
        logic [IDX_W-1:0] pkt_index;
        logic [CNT_W-1:0] frame_pkt_count;
        logic [TS_W-1:0]  pkt_encode_time;
        logic [TS_W-1:0]  pkt_rcv_time;
    } t_frt_in;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [FID_W-1:0] done_frame_id;
        logic [TS_W-1:0]  frame_encode_time;
        logic [TS_W-1:0]  frame_delay;
        logic             missed_deadline;
        logic [FID_W-1:0] played_count;
        logic [FID_W-1:0] highest_frame_id;
    } t_frt_out;

endpackage

// File: design/frt_ram.sv
module frt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/frame_reassembly_tracker.sv
// Frame reassembly tracker.
// Packets enter on the command channel: an item (i_item) is taken at a rising edge where
// start is high and busy is low. Every item produces exactly one result, shown on o_result
// for one cycle with o_done high, after the pipeline registers r0 to r5 and the output
// register. The receiver cannot hold results off.
// Throughput is one item per cycle while busy is low. The slot index (frame id modulo
// the slot count) is found by a two-stage reciprocal multiply, then one slot-table
// read-modify-write per item; the table is a single RAM with a registered read, and a
// forwarding register covers an item whose slot was written by the item just before it.
// After reset, busy stays high while a clearing pass marks every slot empty; the deadline
// register can be written over the APB port during that pass.
// deadline_ns lies at byte address 0 as a 64-bit register (upper 16 bits read as zero).
// Reset also zeroes the played count, the highest frame id and the deadline.
module frame_reassembly_tracker #(
    parameter int FRAME_SLOTS = frt_pkg::FRAME_SLOTS_DEF,
    parameter int MAX_PKTS    = frt_pkg::MAX_PKTS_DEF,
    parameter int TIME_BITS   = frt_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  frt_pkg::t_frt_in                  i_item,
    output logic                              o_done,
    output frt_pkg::t_frt_out                 o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [frt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [frt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [frt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    import frt_pkg::*;

    localparam int SLOT_BITS = $clog2(FRAME_SLOTS);
    localparam int TW        = (TIME_BITS < TS_W) ? TIME_BITS : TS_W;
    localparam int RCP_SHIFT = FID_W + SLOT_BITS;
    localparam int PROD_W    = 2 * FID_W + 1;
    // Rounded-up reciprocal: exact quotient for every 32-bit frame id.
    localparam logic [FID_W:0] RCP = (FID_W + 1)'(((64'd1 << RCP_SHIFT)
        + 64'(FRAME_SLOTS) - 64'd1) / 64'(FRAME_SLOTS));

    typedef struct packed {
        logic                valid;
        logic                played;
        logic [FID_W-1:0]    tag;
        logic [CNT_W-1:0]    expected;
        logic [MAX_PKTS-1:0] seen_map;
        logic [CNT_W-1:0]    seen_count;
        logic [TW-1:0]       min_enc;
        logic [TW-1:0]       max_rcv;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    // Configuration.
    logic [TS_W-1:0] r_deadline;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_DEADLINE)
                  ? APB_DATA_W'(r_deadline) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= '0;
        end else if (cfg_wr && paddr[APB_ADDR_W-1] == REG_DEADLINE) begin
            r_deadline <= pwdata[TS_W-1:0];
        end
    end

    // Clearing pass.
    logic                 r_clr_busy;
    logic [SLOT_BITS-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + SLOT_BITS'(1);
            if (r_clr_addr == SLOT_BITS'(FRAME_SLOTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign busy = r_clr_busy;

    // Slot index: multiply by reciprocal, then subtract quotient times slot count.
    logic                 accept;
    logic                 r0_vld, r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    t_frt_in              r0_item, r1_item, r2_item, r3_item;
    logic [PROD_W-1:0]    r1_prod;
    logic [FID_W-1:0]     r2_qn;
    logic [FID_W-1:0]     s2_diff;
    logic [SLOT_BITS-1:0] s2_slot, r3_slot;

    assign accept  = start && !busy;
    assign s2_diff = r2_item.frame_id - r2_qn;
    assign s2_slot = s2_diff[SLOT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        r0_item <= i_item;
        r1_item <= r0_item;
        r1_prod <= PROD_W'(r0_item.frame_id) * PROD_W'(RCP);
        r2_item <= r1_item;
        r2_qn   <= FID_W'(r1_prod >> RCP_SHIFT) * FID_W'(FRAME_SLOTS);
        r3_item <= r2_item;
        r3_slot <= s2_slot;
    end

    // Slot table.
    logic                 ram_we;
    logic [SLOT_BITS-1:0] ram_waddr;
    t_slot                ram_wdata;
    logic [SLOT_W-1:0]    ram_rdata;

    frt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (FRAME_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (s2_slot),
        .o_rdata (ram_rdata)
    );

    // Read-modify-write of the slot.
    logic                 r_wr_vld;
    logic [SLOT_BITS-1:0] r_wr_slot;
    t_slot                r_wr_data;
    t_slot                cur, base, upd;
    logic                 hit, ignored, complete, s4_write;
    logic [TW-1:0]        enc_m, rcv_m;
    logic [MAX_PKTS-1:0]  pkt_bit;
    logic [FID_W-1:0]     r_played, r_highest;
    logic [STS_W-1:0]     r4_status, r5_status;
    logic [FID_W-1:0]     r4_fid, r5_fid;
    logic [TW-1:0]        r4_enc, r4_rcv, r5_enc, r5_delay;
    logic [FID_W-1:0]     r5_played, r5_highest;

    assign enc_m   = r3_item.pkt_encode_time[TW-1:0];
    assign rcv_m   = r3_item.pkt_rcv_time[TW-1:0];
    // An index at or beyond MAX_PKTS shifts the bit out and is never counted.
    assign pkt_bit = MAX_PKTS'(1) << r3_item.pkt_index;

    always_comb begin
        cur = (r_wr_vld && r_wr_slot == r3_slot) ? r_wr_data : t_slot'(ram_rdata);
        hit = cur.valid && cur.tag == r3_item.frame_id;
        ignored = hit && cur.played;

        base = cur;
        if (!hit) begin
            base.valid      = 1'b1;
            base.played     = 1'b0;
            base.tag        = r3_item.frame_id;
            base.expected   = r3_item.frame_pkt_count;
            base.seen_map   = '0;
            base.seen_count = '0;
            base.min_enc    = enc_m;
            base.max_rcv    = rcv_m;
        end

        upd = base;
        if (rcv_m > base.max_rcv) begin
            upd.max_rcv = rcv_m;
        end
        if (enc_m < base.min_enc) begin
            upd.min_enc = enc_m;
        end
        if (pkt_bit != '0 && (base.seen_map & pkt_bit) == '0) begin
            upd.seen_map   = base.seen_map | pkt_bit;
            upd.seen_count = base.seen_count + CNT_W'(1);
        end
        complete   = upd.seen_count == upd.expected;
        upd.played = complete;
        s4_write   = r3_vld && !ignored;
    end

    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = s4_write;
            ram_waddr = r3_slot;
            ram_wdata = upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_vld  <= 1'b0;
            r_played  <= '0;
            r_highest <= '0;
        end else begin
            r_wr_vld <= s4_write;
            if (s4_write) begin
                if (complete && r_played != '1) begin
                    r_played <= r_played + FID_W'(1);
                end
                if (r3_item.frame_id > r_highest) begin
                    r_highest <= r3_item.frame_id;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_slot <= r3_slot;
        r_wr_data <= upd;
        r4_fid    <= r3_item.frame_id;
        if (ignored) begin
            r4_status <= ST_IGNORED;
            r4_enc    <= '0;
            r4_rcv    <= '0;
        end else begin
            r4_status <= complete ? ST_DONE : ST_PARTIAL;
            r4_enc    <= upd.min_enc;
            r4_rcv    <= upd.max_rcv;
        end
    end

    // Delay, then deadline check into the output register.
    t_frt_out r_out;
    logic     r_done;

    always_ff @(posedge i_clk) begin
        r5_status  <= r4_status;
        r5_fid     <= r4_fid;
        r5_enc     <= r4_enc;
        r5_delay   <= (r4_rcv > r4_enc) ? r4_rcv - r4_enc : '0;
        r5_played  <= r_played;
        r5_highest <= r_highest;

        r_out.status            <= r5_status;
        r_out.done_frame_id     <= r5_fid;
        r_out.frame_encode_time <= TS_W'(r5_enc);
        r_out.frame_delay       <= TS_W'(r5_delay);
        r_out.missed_deadline   <= TS_W'(r5_delay) > r_deadline;
        r_out.played_count      <= r5_played;
        r_out.highest_frame_id  <= r5_highest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r0_vld <= accept;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r_done <= r5_vld;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

`ifndef NO_ASSERTIONS
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##7 o_done)
        else $error("accepted item did not produce a result at the seventh edge");

    a_no_write_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r3_vld)
        else $error("item reached the slot table during the clearing pass");

    a_played_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_played >= $past(r_played))
        else $error("played count decreased");

    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_IGNORED)
        |-> (o_result.frame_delay == '0 && !o_result.missed_deadline))
        else $error("ignored item reported a delay or a missed deadline");
`endif

endmodule

// File: bench/frame_reassembly_tracker_test.sv
`timescale 1ns / 100ps

module frame_reassembly_tracker_test;
    import frt_pkg::*;

    localparam int SLOTS = FRAME_SLOTS_DEF;
    localparam logic [APB_ADDR_W-1:0] DEADLINE_ADDR = {REG_DEADLINE, 3'b000};
    localparam logic [TS_W-1:0] TS_MAX = '1;
    localparam int DRAIN_LIMIT = 200;
    localparam int LATENCY_PAD = 10;
    localparam int FRAMES_OPEN = 4;

    // Mirror of the slot table; predicts one report per accepted packet.
    class frame_table_scoreboard;
        bit               live[SLOTS];
        bit               played[SLOTS];
        logic [FID_W-1:0] tag[SLOTS];
        logic [CNT_W-1:0] want[SLOTS];
        logic [63:0]      seen_map[SLOTS];
        logic [CNT_W-1:0] seen_cnt[SLOTS];
        logic [TS_W-1:0]  min_enc[SLOTS];
        logic [TS_W-1:0]  max_rcv[SLOTS];
        logic [FID_W-1:0] frames_done = '0;
        logic [FID_W-1:0] top_fid = '0;
        logic [TS_W-1:0]  deadline = '0;
        t_frt_out         expected_reports[$];
        int errors = 0;
        int checked = 0;
        int completed = 0;
        int ignored = 0;
        int stored = 0;

        function void track_packet(t_frt_in p);
            int unsigned s;
            t_frt_out r;
            s = p.frame_id % SLOTS;
            r = '0;
            r.done_frame_id = p.frame_id;
            if (live[s] && tag[s] == p.frame_id && played[s]) begin
                r.status = ST_IGNORED;
                ignored++;
            end else begin
                // A different frame id takes the slot over, played or not.
                if (!(live[s] && tag[s] == p.frame_id)) begin
                    live[s]     = 1'b1;
                    played[s]   = 1'b0;
                    tag[s]      = p.frame_id;
                    want[s]     = p.frame_pkt_count;
                    seen_map[s] = '0;
                    seen_cnt[s] = '0;
                    min_enc[s]  = p.pkt_encode_time;
                    max_rcv[s]  = p.pkt_rcv_time;
                end
                if (p.pkt_rcv_time > max_rcv[s])
                    max_rcv[s] = p.pkt_rcv_time;
                if (p.pkt_encode_time < min_enc[s])
                    min_enc[s] = p.pkt_encode_time;
                if (p.pkt_index < MAX_PKTS_DEF && !seen_map[s][p.pkt_index]) begin
                    seen_map[s][p.pkt_index] = 1'b1;
                    seen_cnt[s] = seen_cnt[s] + 1'b1;
                end
                if (p.frame_id > top_fid)
                    top_fid = p.frame_id;
                r.frame_encode_time = min_enc[s];
                r.frame_delay = (max_rcv[s] > min_enc[s]) ? max_rcv[s] - min_enc[s] : '0;
                r.missed_deadline = (r.frame_delay > deadline);
                if (seen_cnt[s] == want[s]) begin
                    played[s] = 1'b1;
                    if (frames_done != '1)
                        frames_done = frames_done + 1'b1;
                    r.status = ST_DONE;
                    completed++;
                end else begin
                    r.status = ST_PARTIAL;
                end
                stored++;
            end
            r.played_count     = frames_done;
            r.highest_frame_id = top_fid;
            expected_reports.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] e, logic [63:0] a);
            if (a !== e) begin
                $error("%s: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_report(t_frt_out got);
            t_frt_out exp_r;
            if (expected_reports.size() == 0) begin
                $error("report for frame %0h with no packet outstanding", got.done_frame_id);
                errors++;
                return;
            end
            exp_r = expected_reports.pop_front();
            checked++;
            compare_field("status", exp_r.status, got.status);
            compare_field("done_frame_id", exp_r.done_frame_id, got.done_frame_id);
            compare_field("frame_encode_time", exp_r.frame_encode_time, got.frame_encode_time);
            compare_field("frame_delay", exp_r.frame_delay, got.frame_delay);
            compare_field("missed_deadline", exp_r.missed_deadline, got.missed_deadline);
            compare_field("played_count", exp_r.played_count, got.played_count);
            compare_field("highest_frame_id", exp_r.highest_frame_id, got.highest_frame_id);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_frt_in               i_item = '0;
    logic                  o_done;
    t_frt_out              o_result;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    frame_table_scoreboard sb;
    int deadline_writes = 0;

    // Frames currently being sent, with the packet indices still to go.
    logic [FID_W-1:0] act_fid[FRAMES_OPEN];
    logic [CNT_W-1:0] act_cnt[FRAMES_OPEN];
    logic [TS_W-1:0]  act_base[FRAMES_OPEN];
    logic [63:0]      act_left[FRAMES_OPEN];
    logic [IDX_W-1:0] act_last[FRAMES_OPEN];
    logic [FID_W-1:0] recent_fids[$];
    logic [FID_W-1:0] next_fid;

    frame_reassembly_tracker dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.track_packet(i_item);
            if (o_done)
                sb.check_report(o_result);
        end
    end

    function automatic logic [TS_W-1:0] rand_time();
        return {16'($urandom), $urandom};
    endfunction

    function automatic t_frt_in make_packet(logic [FID_W-1:0] fid, logic [IDX_W-1:0] idx,
                                            logic [CNT_W-1:0] cnt, logic [TS_W-1:0] enc,
                                            logic [TS_W-1:0] rcv);
        t_frt_in p;
        p.frame_id        = fid;
        p.pkt_index       = idx;
        p.frame_pkt_count = cnt;
        p.pkt_encode_time = enc;
        p.pkt_rcv_time    = rcv;
        return p;
    endfunction

    task automatic send_packet(t_frt_in p, bit idle_on);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= p;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic settle();
        int n;
        n = 0;
        start <= 1'b0;
        while (sb.expected_reports.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        if (sb.expected_reports.size() != 0) begin
            $error("%0d reports never arrived", sb.expected_reports.size());
            sb.errors++;
            sb.expected_reports.delete();
        end
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic write_deadline(logic [TS_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word = {$urandom, $urandom};
        word[TS_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DEADLINE_ADDR;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.deadline = value;
        deadline_writes++;
        // Read the register back; the bits above the deadline read as zero.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(APB_DATA_W - TS_W){1'b0}}, value}) begin
            $error("deadline_ns readback: expected %0h, got %0h", value, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void open_frame(int k);
        int unsigned r;
        int unsigned c;
        r = $urandom_range(0, 99);
        if (r < 70 || recent_fids.size() == 0) begin
            next_fid = next_fid + $urandom_range(1, 3);
            act_fid[k] = next_fid;
        end else if (r < 85) begin
            // Same slot as a recent frame, different tag.
            act_fid[k] = recent_fids[$urandom_range(0, recent_fids.size() - 1)]
                         + SLOTS * $urandom_range(1, 4);
        end else if (r < 92) begin
            act_fid[k] = $urandom;
        end else begin
            act_fid[k] = recent_fids[$urandom_range(0, recent_fids.size() - 1)];
        end
        recent_fids.push_back(act_fid[k]);
        if (recent_fids.size() > 16)
            void'(recent_fids.pop_front());

        r = $urandom_range(0, 99);
        if (r < 60)
            c = $urandom_range(1, 8);
        else if (r < 75)
            c = $urandom_range(9, 20);
        else if (r < 80)
            c = MAX_PKTS_DEF;
        else if (r < 87)
            c = 0;
        else if (r < 94)
            c = $urandom_range(MAX_PKTS_DEF + 1, 127);
        else
            c = $urandom_range(21, MAX_PKTS_DEF - 1);
        act_cnt[k] = CNT_W'(c);
        act_last[k] = '0;

        if (c >= 1 && c <= MAX_PKTS_DEF) begin
            act_left[k] = (c == MAX_PKTS_DEF) ? '1 : (64'd1 << c) - 64'd1;
            // Now and then one packet carries an index outside the frame's count.
            if (c < MAX_PKTS_DEF && c >= 2 && $urandom_range(0, 9) == 0) begin
                act_left[k][$urandom_range(0, c - 1)] = 1'b0;
                act_left[k][$urandom_range(c, MAX_PKTS_DEF - 1)] = 1'b1;
            end
        end else begin
            // A frame that can never complete: send a few packets and move on.
            act_left[k] = '0;
            repeat (3) act_left[k][$urandom_range(0, 63)] = 1'b1;
        end

        r = $urandom_range(0, 19);
        if (r == 0)
            act_base[k] = TS_W'($urandom_range(0, 1000));
        else if (r == 1)
            act_base[k] = TS_MAX - $urandom_range(0, 1000);
        else
            act_base[k] = rand_time();
    endfunction

    task automatic run_random(int target, bit idle_on);
        int unsigned r;
        int k;
        int b;
        int start_at;
        int sent;
        logic [IDX_W-1:0] idx;
        t_frt_in p;
        sent = 0;
        next_fid = $urandom_range(0, 32'h00FF_FFFF) << $urandom_range(0, 8);
        for (k = 0; k < FRAMES_OPEN; k++)
            open_frame(k);
        while (sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                p = make_packet($urandom, IDX_W'($urandom_range(0, 63)),
                                CNT_W'($urandom_range(0, 127)),
                                rand_time(), rand_time());
            end else if (r < 14 && recent_fids.size() != 0) begin
                // Late packet of a frame that is probably already played.
                p = make_packet(recent_fids[$urandom_range(0, recent_fids.size() - 1)],
                                IDX_W'($urandom_range(0, 63)),
                                CNT_W'($urandom_range(0, 127)),
                                rand_time(), rand_time());
            end else begin
                k = $urandom_range(0, FRAMES_OPEN - 1);
                if (act_left[k] == '0)
                    open_frame(k);
                if ($urandom_range(0, 11) == 0) begin
                    idx = act_last[k];
                end else begin
                    start_at = $urandom_range(0, 63);
                    idx = '0;
                    for (b = 0; b < 64; b++) begin
                        if (act_left[k][(start_at + b) % 64]) begin
                            idx = IDX_W'((start_at + b) % 64);
                            break;
                        end
                    end
                    act_left[k][idx] = 1'b0;
                end
                act_last[k] = idx;
                p = make_packet(act_fid[k], idx, act_cnt[k],
                                act_base[k] + $urandom_range(0, 40),
                                ($urandom_range(0, 9) == 0) ?
                                    act_base[k] - $urandom_range(1, 100) :
                                    act_base[k] + $urandom_range(0, 1500));
            end
            send_packet(p, idle_on);
            sent++;
        end
    endtask

    task automatic run_directed();
        // Single-packet frame, then a repeat of it that must be ignored.
        send_packet(make_packet(32'h0, 6'd0, 7'd1, 48'd100, 48'd600), 1'b0);
        send_packet(make_packet(32'h0, 6'd0, 7'd1, 48'd100, 48'd600), 1'b0);
        // Largest frame id, last index, full-range delay.
        send_packet(make_packet(32'hFFFF_FFFF, 6'd63, 7'd1, 48'd0, TS_MAX), 1'b0);
        // Evict the played frame in slot 0; receive before encode gives zero delay.
        send_packet(make_packet(32'h200, 6'd1, 7'd2, 48'd5000, 48'd4000), 1'b0);
        // The evicted frame comes back and starts afresh.
        send_packet(make_packet(32'h0, 6'd0, 7'd1, 48'd700, 48'd900), 1'b0);
        // Three-packet frame with a duplicate that moves both times.
        send_packet(make_packet(32'h10, 6'd2, 7'd3, 48'd2000, 48'd2100), 1'b0);
        send_packet(make_packet(32'h10, 6'd2, 7'd3, 48'd1500, 48'd3000), 1'b0);
        send_packet(make_packet(32'h10, 6'd0, 7'd3, 48'd2500, 48'd2600), 1'b0);
        send_packet(make_packet(32'h10, 6'd1, 7'd3, 48'd2500, 48'd2600), 1'b0);
        send_packet(make_packet(32'h10, 6'd1, 7'd3, 48'd0, TS_MAX), 1'b0);
        // Frames that can never complete (zero count, a count past the limit), then one at the limit.
        send_packet(make_packet(32'h21, 6'd0, 7'd0, 48'd10, 48'd20), 1'b0);
        send_packet(make_packet(32'h21, 6'd5, 7'd0, 48'd5, 48'd30), 1'b0);
        send_packet(make_packet(32'h22, 6'd0, 7'd127, 48'd10, 48'd20), 1'b0);
        send_packet(make_packet(32'h22, 6'd63, 7'd127, 48'd10, 48'd20), 1'b0);
        send_packet(make_packet(32'h23, 6'd63, 7'd64, 48'd40, 48'd50), 1'b0);
        // Collision on the slot of 0x23, then 0x23 returns with a new count.
        send_packet(make_packet(32'h123, 6'd0, 7'd2, 48'd40, 48'd50), 1'b0);
        send_packet(make_packet(32'h23, 6'd0, 7'd1, 48'd60, 48'd70), 1'b0);
        // Indices outside the frame's count still count toward completion.
        send_packet(make_packet(32'h24, 6'd5, 7'd2, 48'd100, 48'd1200), 1'b0);
        send_packet(make_packet(32'h24, 6'd40, 7'd2, 48'd100, 48'd1100), 1'b0);
        send_packet(make_packet(32'h30, 6'd0, 7'd1, TS_MAX, 48'd0), 1'b0);
        send_packet(make_packet(32'h31, 6'd0, 7'd1, TS_MAX, TS_MAX), 1'b0);
        send_packet(make_packet(32'h7FFF_FFFF, 6'd0, 7'd1, 48'd0, 48'd1001), 1'b0);
    endtask

    initial begin
        sb = new;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_deadline(48'd1000);
        run_directed();
        settle();
        write_deadline(48'd500);
        run_random(107, 1'b1);
        settle();
        write_deadline(TS_MAX);
        run_random(107, 1'b1);
        settle();
        write_deadline(TS_W'($urandom_range(200, 1500)));
        run_random(107, 1'b1);
        settle();
        write_deadline('0);
        run_random(107, 1'b0);
        settle();
        $display("%0d reports checked: %0d frames completed, %0d packets of played frames",
                 sb.checked, sb.completed, sb.ignored);
        $display("ignored, across %0d deadline settings", deadline_writes);
        if (sb.errors == 0)
            $display("frame_reassembly_tracker: match");
        else
            $display("frame_reassembly_tracker: mismatch");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout waiting for the tracker");
        $display("frame_reassembly_tracker: mismatch");
        $finish;
    end

endmodule
